// ===== hdl/csq_pkg.sv =====
// Shared types and constants for the counting semaphore wait queue.
`default_nettype none

package csq_pkg;

  localparam int CSQ_QUEUE_DEPTH    = 16;
  localparam int CSQ_THREAD_ID_BITS = 8;

  localparam int THREAD_W = 8;
  localparam int INIT_W   = 15;
  localparam int COUNT_W  = 16;

  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sd32767;

  localparam logic [1:0] OP_WAIT   = 2'd0;
  localparam logic [1:0] OP_SIGNAL = 2'd1;
  localparam logic [1:0] OP_CLOSE  = 2'd2;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_SAT  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [THREAD_W-1:0] thread_id;
  } cmd_t;

  typedef struct packed {
    logic                caller_blocks;
    logic                wake_valid;
    logic [THREAD_W-1:0] wake_thread;
    logic [1:0]          status;
    logic                last;
  } result_t;

  typedef struct packed {
    logic push;
    logic pop;
  } chain_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic single;
  } chain_sts_t;

endpackage

`default_nettype wire

// ===== hdl/csq_cell.sv =====
// One queue cell: holds a thread identifier and passes it towards the head on a pop.
`default_nettype none

module csq_cell #(
  parameter int ID_BITS = 8
) (
  input  wire logic               clk,
  input  wire logic               shift,
  input  wire logic               load,
  input  wire logic [ID_BITS-1:0] new_id,
  input  wire logic [ID_BITS-1:0] right_id,
  output logic      [ID_BITS-1:0] id
);

  always_ff @(posedge clk) begin
    if (shift) begin
      id <= right_id;
    end else if (load) begin
      id <= new_id;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/csq_chain.sv =====
// Row of queue cells with the occupancy count; cell 0 is the oldest waiting thread.
`default_nettype none

module csq_chain
  import csq_pkg::*;
#(
  parameter int QUEUE_DEPTH    = CSQ_QUEUE_DEPTH,
  parameter int THREAD_ID_BITS = CSQ_THREAD_ID_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire chain_ctl_t                ctl,
  input  wire logic [THREAD_ID_BITS-1:0] new_id,
  output logic      [THREAD_ID_BITS-1:0] head_id,
  output chain_sts_t                     sts
);

  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

  logic [OCC_W-1:0]          occupancy;
  logic [OCC_W-1:0]          occupancy_next;
  logic [THREAD_ID_BITS-1:0] ids [0:QUEUE_DEPTH];

  assign ids[QUEUE_DEPTH] = '0;

  // A push lands in the first empty cell, which sits at the occupancy index.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    csq_cell #(
      .ID_BITS (THREAD_ID_BITS)
    ) u_cell (
      .clk      (clk),
      .shift    (ctl.pop),
      .load     (ctl.push && (occupancy == OCC_W'(i))),
      .new_id   (new_id),
      .right_id (ids[i+1]),
      .id       (ids[i])
    );
  end

  always_comb begin
    occupancy_next = occupancy;
    if (ctl.push) begin
      occupancy_next = occupancy + OCC_W'(1);
    end else if (ctl.pop) begin
      occupancy_next = occupancy - OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else begin
      occupancy <= occupancy_next;
    end
  end

  assign head_id    = ids[0];
  assign sts.empty  = (occupancy == '0);
  assign sts.full   = (occupancy == OCC_W'(QUEUE_DEPTH));
  assign sts.single = (occupancy == OCC_W'(1));

endmodule

`default_nettype wire

// ===== hdl/counting_semaphore_wait_queue.sv =====
// Counting semaphore with a first-in first-out queue of waiting threads.
//
//   channel   ports                     transfer when
//   command   start, busy, cmd          start high and busy low
//   result    done, result              done high (cannot be held off)
//   config    cfg_we, cfg_data          cfg_we high
//
// A wait or signal is taken and its single result appears on the next cycle,
// and a new command may be taken every cycle.
// A close with k queued threads gives max(k,1) results on consecutive cycles, one cell
// of the queue chain shifted out per cycle; busy stays high until the last is out.
// Synchronous reset empties the queue and sets the count and initial count to zero.
// The receiver cannot stall; results are never held back.
`default_nettype none

module counting_semaphore_wait_queue
  import csq_pkg::*;
#(
  parameter int QUEUE_DEPTH    = CSQ_QUEUE_DEPTH,
  parameter int THREAD_ID_BITS = CSQ_THREAD_ID_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire cmd_t              cmd,
  output logic                   done,
  output result_t                result,
  input  wire logic              cfg_we,
  input  wire logic [INIT_W-1:0] cfg_data
);

  state_t                     state;
  state_t                     state_next;
  logic signed [COUNT_W-1:0]  count;
  logic signed [COUNT_W-1:0]  count_next;
  logic signed [COUNT_W-1:0]  count_inc;
  logic [INIT_W-1:0]          initial_count;
  result_t                    result_next;
  logic                       done_next;
  chain_ctl_t                 ctl;
  chain_sts_t                 sts;
  logic [THREAD_ID_BITS-1:0]  head_id;
  logic                       accept;

  assign accept    = start && !busy;
  assign busy      = (state == ST_DRAIN);
  assign count_inc = count + 16'sd1;

  csq_chain #(
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .THREAD_ID_BITS (THREAD_ID_BITS)
  ) u_chain (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .new_id  (THREAD_ID_BITS'(cmd.thread_id)),
    .head_id (head_id),
    .sts     (sts)
  );

  always_comb begin
    state_next         = state;
    count_next         = count;
    ctl                = '0;
    done_next          = 1'b0;
    result_next        = '0;
    result_next.last   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          done_next = 1'b1;
          case (cmd.opcode)
            OP_WAIT: begin
              if (count <= 16'sd0) begin
                if (sts.full) begin
                  result_next.status = STAT_FULL;
                end else begin
                  ctl.push                  = 1'b1;
                  count_next                = count - 16'sd1;
                  result_next.caller_blocks = 1'b1;
                end
              end else begin
                count_next = count - 16'sd1;
              end
            end
            OP_SIGNAL: begin
              if (count == COUNT_MAX) begin
                result_next.status = STAT_SAT;
              end else begin
                count_next = count_inc;
                if (count_inc <= 16'sd0 && !sts.empty) begin
                  ctl.pop                 = 1'b1;
                  result_next.wake_valid  = 1'b1;
                  result_next.wake_thread = THREAD_W'(head_id);
                end
              end
            end
            OP_CLOSE: begin
              // The count is not consulted again until the drain ends, so reload it now.
              count_next = $signed({1'b0, initial_count});
              if (!sts.empty) begin
                ctl.pop                 = 1'b1;
                result_next.wake_valid  = 1'b1;
                result_next.wake_thread = THREAD_W'(head_id);
                result_next.last        = sts.single;
                if (!sts.single) begin
                  state_next = ST_DRAIN;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DRAIN: begin
        done_next               = 1'b1;
        ctl.pop                 = 1'b1;
        result_next.wake_valid  = 1'b1;
        result_next.wake_thread = THREAD_W'(head_id);
        result_next.last        = sts.single;
        if (sts.single) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      initial_count <= '0;
      done          <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
      if (cfg_we) begin
        initial_count <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(ctl.push && sts.full))
    else $error("push into a full queue chain");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    !(ctl.pop && sts.empty))
    else $error("pop from an empty queue chain");

  a_negative_count_has_waiters: assert property (@(posedge clk) disable iff (rst)
    (count < 16'sd0) |-> !sts.empty)
    else $error("negative count with no queued thread");

  a_drain_not_empty: assert property (@(posedge clk) disable iff (rst)
    busy |-> !sts.empty)
    else $error("draining an empty queue");

  a_drain_emits: assert property (@(posedge clk) disable iff (rst)
    busy |=> done)
    else $error("drain cycle gave no result");

  a_non_last_followed: assert property (@(posedge clk) disable iff (rst)
    (done && !result.last) |-> busy)
    else $error("unfinished close without drain in progress");

endmodule

`default_nettype wire
